FILE: hw/rtl/chqp_pkg.sv
`default_nettype none

package chqp_pkg;

    localparam int KEY_W  = 31;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 10;
    localparam int OCC_W  = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_NEW   = 3'd0;
    localparam logic [STAT_W-1:0] ST_INC   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] home_bucket;
        logic [OCC_W-1:0]  occurrences;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/chqp_ram.sv
`default_nettype none

module chqp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/chqp_home.sv
`default_nettype none

module chqp_home #(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [chqp_pkg::KEY_W-1:0]      i_key,
    output logic                                 o_done,
    output logic      [$clog2(TABLE_SIZE)-1:0]   o_home
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    generate
        if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
            logic             r_done;
            logic [IDX_W-1:0] r_home;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_home <= i_key[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_div
            // restoring remainder, 4 key bits a cycle, msb first
            logic             r_busy;
            logic             r_done;
            logic [2:0]       r_it;
            logic [31:0]      r_sh;
            logic [IDX_W-1:0] r_rem;
            logic [IDX_W-1:0] n_rem;

            always_comb begin
                logic [IDX_W:0] t;
                t     = '0;
                n_rem = r_rem;
                for (int j = 0; j < 4; j++) begin
                    t = {n_rem, r_sh[31-j]};
                    if (t >= (IDX_W+1)'(TABLE_SIZE)) begin
                        t = t - (IDX_W+1)'(TABLE_SIZE);
                    end
                    n_rem = t[IDX_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_it   <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_it   <= '0;
                    end else if (r_busy) begin
                        r_it <= r_it + 3'd1;
                        if (r_it == 3'd7) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_sh  <= {1'b0, i_key};
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_sh  <= {r_sh[27:0], 4'b0000};
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_home = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: hw/rtl/counting_hash_table_quadratic_probe.sv
`default_nettype none

// Home slot: a table size that is not a power of two needs a home-slot remainder (4 key
//   bits a cycle); a search ends on a hit or once it runs out of probes.
// Throughput: one word at a time; one probe per cycle through the slot RAM read port,
//   next word taken in the cycle after the result is loaded into the output register.
// Reset: synchronous; then a clearing pass marks all slots unused, input ready stays
//   low until it ends.
module counting_hash_table_quadratic_probe #(
    parameter int TABLE_SIZE = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire chqp_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output chqp_pkg::t_out_word       o_out_word
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = IDX_W + 1;
    localparam int KEY_W   = chqp_pkg::KEY_W;
    localparam int ENTRY_W = 1 + KEY_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    chqp_pkg::t_state r_state, n_state;

    logic                  r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [IDX_W-1:0]      r_clr_addr;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_step;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_chk_vld;
    logic [IDX_W-1:0]      r_chk_idx;

    logic [chqp_pkg::STAT_W-1:0] r_res_status;
    logic [IDX_W-1:0]            r_res_slot;
    logic [COUNT_BITS-1:0]       r_res_count;
    logic                        r_wr_en;
    logic [ENTRY_W-1:0]          r_wr_data;

    logic                  r_out_vld;
    chqp_pkg::t_out_word   r_out;

    logic                  home_start;
    logic                  home_done;
    logic [IDX_W-1:0]      home;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  ent_used;
    logic [KEY_W-1:0]      ent_key;
    logic [COUNT_BITS-1:0] ent_count;
    logic                  hit;
    logic                  exhausted;
    logic                  out_free;
    logic                  in_fire;

    logic [IDX_W:0]        idx_sum;
    logic [IDX_W:0]        step_sum;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      step_next;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == chqp_pkg::S_IDLE);
    assign out_free   = !r_out_vld || i_out_ready;
    assign home_start = in_fire;

    chqp_home #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_home (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(home_start),
        .i_key  (i_in_word.key),
        .o_done (home_done),
        .o_home (home)
    );

    chqp_ram #(
        .DEPTH(TABLE_SIZE),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    assign ent_used  = ram_rdata[ENTRY_W-1];
    assign ent_key   = ram_rdata[ENTRY_W-2 -: KEY_W];
    assign ent_count = ram_rdata[COUNT_BITS-1:0];

    assign hit       = r_chk_vld && (!ent_used || (ent_key == r_key));
    assign exhausted = !r_chk_vld && (r_cnt == CNT_W'(TABLE_SIZE));
    assign ram_re    = (r_state == chqp_pkg::S_PROBE) && (r_cnt != CNT_W'(TABLE_SIZE));

    // quadratic step: idx += 2i+1 (mod size)
    assign idx_sum   = {1'b0, r_idx} + {1'b0, r_step};
    assign idx_next  = (idx_sum >= (IDX_W+1)'(TABLE_SIZE))
                     ? IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : idx_sum[IDX_W-1:0];
    assign step_sum  = {1'b0, r_step} + (IDX_W+1)'(2);
    assign step_next = (step_sum >= (IDX_W+1)'(TABLE_SIZE))
                     ? IDX_W'(step_sum - (IDX_W+1)'(TABLE_SIZE)) : step_sum[IDX_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_res_slot;
        ram_wdata = r_wr_data;
        if (r_state == chqp_pkg::S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == chqp_pkg::S_DONE && out_free && r_wr_en) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chqp_pkg::S_CLEAR: begin
                if (r_clr_addr == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = chqp_pkg::S_IDLE;
                end
            end
            chqp_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = chqp_pkg::S_HOME;
                end
            end
            chqp_pkg::S_HOME: begin
                if (home_done) begin
                    n_state = chqp_pkg::S_PROBE;
                end
            end
            chqp_pkg::S_PROBE: begin
                if (hit || exhausted) begin
                    n_state = chqp_pkg::S_DONE;
                end
            end
            chqp_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = chqp_pkg::S_IDLE;
                end
            end
            default: n_state = chqp_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= chqp_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_chk_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == chqp_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            r_chk_vld <= ram_re;
            if (r_state == chqp_pkg::S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_in_word.kind;
            r_key  <= i_in_word.key;
        end
        if (r_state == chqp_pkg::S_HOME) begin
            r_idx  <= home;
            r_step <= IDX_W'(1);
            r_cnt  <= '0;
        end else if (ram_re) begin
            r_idx  <= idx_next;
            r_step <= step_next;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (ram_re) begin
            r_chk_idx <= r_idx;
        end
        if (r_state == chqp_pkg::S_PROBE && (hit || exhausted)) begin
            r_wr_en     <= 1'b0;
            r_res_slot  <= r_chk_idx;
            r_res_count <= '0;
            if (!hit) begin
                r_res_slot   <= home;
                r_res_status <= (r_kind == chqp_pkg::KIND_INSERT)
                              ? chqp_pkg::ST_FULL : chqp_pkg::ST_MISS;
            end else if (r_kind == chqp_pkg::KIND_INSERT) begin
                r_wr_en <= 1'b1;
                if (ent_used) begin
                    r_res_status <= chqp_pkg::ST_INC;
                    r_res_count  <= (ent_count == CNT_MAX)
                                  ? ent_count : ent_count + COUNT_BITS'(1);
                    r_wr_data    <= {1'b1, r_key, (ent_count == CNT_MAX)
                                  ? ent_count : ent_count + COUNT_BITS'(1)};
                end else begin
                    r_res_status <= chqp_pkg::ST_NEW;
                    r_res_count  <= COUNT_BITS'(1);
                    r_wr_data    <= {1'b1, r_key, COUNT_BITS'(1)};
                end
            end else if (ent_used) begin
                r_res_status <= chqp_pkg::ST_FOUND;
                r_res_count  <= ent_count;
            end else begin
                r_res_status <= chqp_pkg::ST_MISS;
            end
        end
        if (r_state == chqp_pkg::S_DONE && out_free) begin
            r_out.status      <= r_res_status;
            r_out.slot        <= chqp_pkg::SLOT_W'(17'(r_res_slot));
            r_out.home_bucket <= chqp_pkg::SLOT_W'(17'(home));
            r_out.occurrences <= chqp_pkg::OCC_W'(33'(r_res_count));
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chqp_pkg::S_PROBE) |-> (r_idx < IDX_W'(TABLE_SIZE - 1)
            || r_idx == IDX_W'(TABLE_SIZE - 1)))
        else $error("probe index out of range");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chqp_pkg::S_PROBE) |-> (r_cnt <= CNT_W'(TABLE_SIZE)))
        else $error("probe count beyond table size");

    a_wr_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != chqp_pkg::S_CLEAR) |-> (r_kind == chqp_pkg::KIND_INSERT))
        else $error("slot write on lookup");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> $stable(r_out))
        else $error("result overwritten before taken");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (home_done && r_state != chqp_pkg::S_HOME) |-> 1'b0)
        else $error("home slot ready outside home state");

endmodule

`default_nettype wire
